### src/morse_letter_keyer_macros.svh
// ----------------------------------------------------------------------------
// Morse letter keyer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MORSE_LETTER_KEYER_MACROS_SVH
`define MORSE_LETTER_KEYER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define MLK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define MLK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mlk_pkg.sv
// ----------------------------------------------------------------------------
// Morse letter keyer package
// Widths, constants, command types and the Morse code table.
// ----------------------------------------------------------------------------
package mlk_pkg;

  // Field and counter widths.
  localparam int CHAR_W  = 8;
  localparam int CODE_W  = 13;
  localparam int LEN_W   = 4;
  localparam int TAIL_W  = 6;
  localparam int PAUSE_W = 6;
  localparam int IDX_W   = 5;

  // Configuration port geometry.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register index of pause_length.
  localparam logic [APB_AW-3:0] REG_PAUSE_LENGTH = '0;

  // Keying constants.
  localparam logic [PAUSE_W-1:0] PAUSE_MAX   = 6'd51;
  localparam logic [PAUSE_W-1:0] PAUSE_RESET = 6'd50;
  localparam logic [TAIL_W-1:0]  LETTER_GAP  = 6'd3;

  // ASCII range of the letters.
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;

  // Default depth of the command queue.
  localparam int QUEUE_DEPTH_DEF = 4;

  // One table entry: pattern left-aligned, first unit in the MSB.
  typedef struct packed {
    logic [CODE_W-1:0] pat;
    logic [LEN_W-1:0]  len;
  } mlk_code_t;

  // One queued command: the code of a character plus its trailing off units.
  typedef struct packed {
    logic [CODE_W-1:0] pat;
    logic [LEN_W-1:0]  len;
    logic [TAIL_W-1:0] tail;
  } mlk_cmd_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } mlk_qstat_t;

  // Morse table: index 0 is space, 1 to 26 are A to Z.
  function automatic mlk_code_t code_lookup(logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] raw;
    logic [LEN_W-1:0]  len;
    mlk_code_t         res;
    unique case (idx)
      5'd1:    begin raw = 13'b10111;         len = 4'd5;  end
      5'd2:    begin raw = 13'b111010101;     len = 4'd9;  end
      5'd3:    begin raw = 13'b11101011101;   len = 4'd11; end
      5'd4:    begin raw = 13'b1110101;       len = 4'd7;  end
      5'd5:    begin raw = 13'b1;             len = 4'd1;  end
      5'd6:    begin raw = 13'b101011101;     len = 4'd9;  end
      5'd7:    begin raw = 13'b111011101;     len = 4'd9;  end
      5'd8:    begin raw = 13'b1010101;       len = 4'd7;  end
      5'd9:    begin raw = 13'b101;           len = 4'd3;  end
      5'd10:   begin raw = 13'b1011101110111; len = 4'd13; end
      5'd11:   begin raw = 13'b111010111;     len = 4'd9;  end
      5'd12:   begin raw = 13'b101110101;     len = 4'd9;  end
      5'd13:   begin raw = 13'b1110111;       len = 4'd7;  end
      5'd14:   begin raw = 13'b11101;         len = 4'd5;  end
      5'd15:   begin raw = 13'b11101110111;   len = 4'd11; end
      5'd16:   begin raw = 13'b10111011101;   len = 4'd11; end
      5'd17:   begin raw = 13'b1110111010111; len = 4'd13; end
      5'd18:   begin raw = 13'b1011101;       len = 4'd7;  end
      5'd19:   begin raw = 13'b10101;         len = 4'd5;  end
      5'd20:   begin raw = 13'b111;           len = 4'd3;  end
      5'd21:   begin raw = 13'b1010111;       len = 4'd7;  end
      5'd22:   begin raw = 13'b101010111;     len = 4'd9;  end
      5'd23:   begin raw = 13'b101110111;     len = 4'd9;  end
      5'd24:   begin raw = 13'b11101010111;   len = 4'd11; end
      5'd25:   begin raw = 13'b1110101110111; len = 4'd13; end
      5'd26:   begin raw = 13'b11101110101;   len = 4'd11; end
      default: begin raw = 13'b0;             len = 4'd1;  end
    endcase
    res.pat = raw << (CODE_W - int'(len));
    res.len = len;
    return res;
  endfunction

endpackage

### src/mlk_if.sv
// ----------------------------------------------------------------------------
// Morse letter keyer channel interfaces
// Valid/ready channels for the character input and the keying output.
// ----------------------------------------------------------------------------

// Character channel: one item per character.
interface mlk_in_if;
  logic                        valid;
  logic                        ready;
  logic [mlk_pkg::CHAR_W-1:0]  character;
  logic                        end_of_message;

  modport source (output valid, output character, output end_of_message, input ready);
  modport sink   (input valid, input character, input end_of_message, output ready);
endinterface

// Keying channel: one item per time unit.
interface mlk_out_if;
  logic valid;
  logic ready;
  logic led_on;
  logic last_bit;

  modport source (output valid, output led_on, output last_bit, input ready);
  modport sink   (input valid, input led_on, input last_bit, output ready);
endinterface

### src/morse_letter_keyer.sv
// ----------------------------------------------------------------------------
// Morse letter keyer
// The first keying unit of a character passes the command queue and the output
// register. Throughput: one keying unit per cycle while the output is ready;
// a character keys as code length plus gap or pause units (1 to 64), played by
// the single back-end sequencer. Characters are taken every cycle while the
// command queue has room. Reset (rst_n low, synchronous) empties the queue,
// idles the output and sets pause_length to 50.
// ----------------------------------------------------------------------------
module morse_letter_keyer #(
  parameter int QUEUE_DEPTH = mlk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mlk_in_if.sink                     in_chan,
  mlk_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mlk_pkg::APB_AW-1:0] paddr,
  input  logic [mlk_pkg::APB_DW-1:0] pwdata,
  output logic [mlk_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import mlk_pkg::*;

  logic [PAUSE_W-1:0]  pause_r;
  logic [APB_AW-3:0]   reg_idx;
  logic                cfg_wr;
  logic                push;
  logic                pop;
  mlk_cmd_t            push_cmd;
  mlk_cmd_t            head_cmd;
  mlk_qstat_t          q_stat;

  // Configuration register access.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_PAUSE_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_r <= PAUSE_RESET;
    end else if (cfg_wr) begin
      pause_r <= pwdata[PAUSE_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_PAUSE_LENGTH) ? APB_DW'(pause_r) : '0;

  // Front end: classify characters into commands.
  mlk_front u_front (
    .in_chan   (in_chan),
    .pause_len (pause_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Command queue between front and back.
  mlk_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // Back end: key out the commands.
  mlk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

### src/mlk_front.sv
// ----------------------------------------------------------------------------
// Morse letter keyer front end
// Accepts characters, looks up their codes and queues keying commands.
// ----------------------------------------------------------------------------
module mlk_front (
  mlk_in_if.sink                      in_chan,
  input  logic [mlk_pkg::PAUSE_W-1:0] pause_len,
  input  mlk_pkg::mlk_qstat_t         q_stat,
  output logic                        push,
  output mlk_pkg::mlk_cmd_t           push_cmd
);
  import mlk_pkg::*;

  logic [IDX_W-1:0]  idx;
  logic [TAIL_W-1:0] tail;
  mlk_code_t         code;

  // Take a character whenever the queue has room.
  assign in_chan.ready = !q_stat.full;
  assign push          = in_chan.valid && !q_stat.full;

  // Letters map to table entries 1 to 26; anything else keys as a space.
  always_comb begin
    if (in_chan.character >= CHAR_A && in_chan.character <= CHAR_Z) begin
      idx = IDX_W'(in_chan.character - CHAR_A) + IDX_W'(1);
    end else begin
      idx = '0;
    end
  end

  assign code = code_lookup(idx);

  // The last character of a message is followed by the clamped pause.
  always_comb begin
    if (in_chan.end_of_message) begin
      tail = (pause_len > PAUSE_MAX) ? TAIL_W'(PAUSE_MAX) : TAIL_W'(pause_len);
    end else begin
      tail = LETTER_GAP;
    end
  end

  assign push_cmd.pat  = code.pat;
  assign push_cmd.len  = code.len;
  assign push_cmd.tail = tail;

endmodule

### src/mlk_fifo.sv
// ----------------------------------------------------------------------------
// Morse letter keyer command queue
// Small register queue that decouples the front end from the keying back end.
// ----------------------------------------------------------------------------
module mlk_fifo #(
  parameter int DEPTH = mlk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mlk_pkg::mlk_cmd_t   push_cmd,
  input  logic                pop,
  output mlk_pkg::mlk_cmd_t   head_cmd,
  output mlk_pkg::mlk_qstat_t q_stat
);
  import mlk_pkg::*;

  `include "morse_letter_keyer_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mlk_cmd_t         entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Pointers wrap at the queue depth.
  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);

  // Fill count follows pushes and pops.
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd     = entry_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  // Queue must never overflow or underflow.
  `MLK_ASSERT_IMP(a_no_overflow, push, cnt_r != CNT_W'(DEPTH), "push into a full queue")
  `MLK_ASSERT_IMP(a_no_underflow, pop, cnt_r != '0, "pop from an empty queue")

endmodule

### src/mlk_back.sv
// ----------------------------------------------------------------------------
// Morse letter keyer back end
// Plays queued commands out into an output register, one keying unit per cycle while the output is ready.
// ----------------------------------------------------------------------------
module mlk_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mlk_pkg::mlk_cmd_t   head_cmd,
  input  mlk_pkg::mlk_qstat_t q_stat,
  output logic                pop,
  mlk_out_if.source           out_chan
);
  import mlk_pkg::*;

  `include "morse_letter_keyer_macros.svh"

  logic              busy_r, busy_nxt;
  logic [CODE_W-1:0] pat_r, pat_nxt;
  logic [LEN_W-1:0]  code_cnt_r, code_cnt_nxt;
  logic [TAIL_W-1:0] tail_cnt_r, tail_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              led_r, led_nxt;
  logic              last_r, last_nxt;

  logic              advance;
  logic              have_work;
  logic              step;
  logic [CODE_W-1:0] cur_pat;
  logic [LEN_W-1:0]  cur_code;
  logic [TAIL_W-1:0] cur_tail;
  logic              emit_code;
  logic              emit_last;

  // The output register can take a new unit when empty or being drained.
  assign advance   = !out_valid_r || out_chan.ready;
  assign have_work = busy_r || !q_stat.empty;
  assign step      = advance && have_work;
  assign pop       = step && !busy_r;

  // Work on the current command, or start the queue head with no bubble.
  assign cur_pat  = busy_r ? pat_r      : head_cmd.pat;
  assign cur_code = busy_r ? code_cnt_r : head_cmd.len;
  assign cur_tail = busy_r ? tail_cnt_r : head_cmd.tail;

  assign emit_code = (cur_code != '0);
  assign emit_last = emit_code ? (cur_code == LEN_W'(1) && cur_tail == '0)
                               : (cur_tail == TAIL_W'(1));

  // Next state of the sequencer and the output register.
  always_comb begin
    busy_nxt      = busy_r;
    pat_nxt       = pat_r;
    code_cnt_nxt  = code_cnt_r;
    tail_cnt_nxt  = tail_cnt_r;
    out_valid_nxt = out_valid_r;
    led_nxt       = led_r;
    last_nxt      = last_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      last_nxt      = emit_last;
      busy_nxt      = !emit_last;
      if (emit_code) begin
        led_nxt      = cur_pat[CODE_W-1];
        pat_nxt      = cur_pat << 1;
        code_cnt_nxt = cur_code - LEN_W'(1);
        tail_cnt_nxt = cur_tail;
      end else begin
        led_nxt      = 1'b0;
        pat_nxt      = cur_pat;
        code_cnt_nxt = '0;
        tail_cnt_nxt = cur_tail - TAIL_W'(1);
      end
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r      <= pat_nxt;
    code_cnt_r <= code_cnt_nxt;
    tail_cnt_r <= tail_cnt_nxt;
    led_r      <= led_nxt;
    last_r     <= last_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.led_on   = led_r;
  assign out_chan.last_bit = last_r;

  // A busy sequencer always has units left, and the last unit ends the command.
  `MLK_ASSERT_IMP(a_busy_has_units, busy_r, code_cnt_r != '0 || tail_cnt_r != '0,
                  "busy with no units left")
  `MLK_ASSERT_NXT(a_last_ends_cmd, step && emit_last, !busy_r && last_r,
                  "command did not end on its last unit")
  `MLK_ASSERT_NXT(a_mid_stays_busy, step && !emit_last, busy_r && !last_r,
                  "command ended before its last unit")

endmodule

### tb/morse_letter_keyer_tb.sv
// ----------------------------------------------------------------------------
// Morse letter keyer testbench
// Sends characters through the input channel and checks every keying unit
// against an in-bench predictor that builds each pattern from dot/dash
// spellings. The output side stalls in random bursts, the pause register is
// swept through its range over APB, and the run ends with a stall-free burst.
// ----------------------------------------------------------------------------
module morse_letter_keyer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlk_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;

  // Byte addresses of the pause register and of an unused register slot.
  localparam logic [APB_AW-1:0] PAUSE_ADDR = {REG_PAUSE_LENGTH, 2'b00};
  localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_PAUSE_LENGTH, 2'b00};

  // One expected keying unit.
  typedef struct packed {
    logic led_on;
    logic last_bit;
  } key_unit_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mlk_in_if  in_if ();
  mlk_out_if out_if ();

  morse_letter_keyer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Dot/dash spelling of A to Z.
  string morse_spelling [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  key_unit_t         pending_units[$];
  logic [PAUSE_W-1:0] pause_setting;
  bit                quiet;
  int                mismatches;
  int                chars_sent;
  int                units_seen;
  int                reg_writes;
  int                cycles;

  always #5 clk = ~clk;

  // Expected keying units of one character, appended to the pending store.
  function automatic void key_character(logic [CHAR_W-1:0] ch, logic eom);
    logic      levels[$];
    string     spell;
    int        tail;
    key_unit_t u;
    if (ch >= CHAR_A && ch <= CHAR_Z) begin
      spell = morse_spelling[ch - CHAR_A];
      for (int i = 0; i < spell.len(); i++) begin
        if (i > 0) levels.push_back(1'b0);
        levels.push_back(1'b1);
        if (spell[i] == "-") begin
          levels.push_back(1'b1);
          levels.push_back(1'b1);
        end
      end
    end else begin
      // Space and every unknown code key as one off unit.
      levels.push_back(1'b0);
    end
    if (eom) begin
      tail = (pause_setting > PAUSE_MAX) ? int'(PAUSE_MAX) : int'(pause_setting);
    end else begin
      tail = int'(LETTER_GAP);
    end
    repeat (tail) levels.push_back(1'b0);
    foreach (levels[i]) begin
      u.led_on = levels[i];
      u.last_bit = (i == levels.size() - 1);
      pending_units.push_back(u);
    end
  endfunction

  // Send one character and record its keying once it is taken.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eom);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.character <= ch;
    in_if.end_of_message <= eom;
    do @(posedge clk); while (!in_if.ready);
    key_character(ch, eom);
    chars_sent++;
  endtask

  // Send a whole message; the last character closes it.
  task automatic send_text(input string msg);
    for (int i = 0; i < msg.len(); i++) begin
      send_char(msg[i], i == msg.len() - 1);
    end
  endtask

  // Let every expected unit come out before touching the register.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[APB_AW-1:2] == REG_PAUSE_LENGTH) pause_setting = data[PAUSE_W-1:0];
    reg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read the pause register and compare it with the predicted setting.
  task automatic check_pause_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PAUSE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(pause_setting)) begin
      $display("%0t: pause readback expected %0d, got %0d", $time, pause_setting, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reset value of the pause, with the shortest and a longest letter at that pause.
  task automatic test_reset_pause();
    check_pause_readback();
    send_text("E");
    send_text("Y");
    settle();
  endtask

  // Shortest and longest codes, with letter gaps between them.
  task automatic test_code_extremes();
    send_text("ETJQ Z");
    settle();
  endtask

  // Codes outside A to Z, lower case among them, key as a space.
  task automatic test_unknown_codes();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h5B, 1'b0);
    send_char("a", 1'b0);
    send_char("z", 1'b1);
    settle();
  endtask

  // Zero pause, the largest pause, saturation above it and ignored writes.
  task automatic test_pause_edges();
    apb_write(PAUSE_ADDR, '0);
    check_pause_readback();
    send_text("T");
    send_text(" ");
    settle();
    apb_write(PAUSE_ADDR, APB_DW'(PAUSE_MAX));
    send_text("Q");
    settle();
    apb_write(PAUSE_ADDR, 32'hFFFF_FFFF);
    check_pause_readback();
    send_text("E");
    settle();
    apb_write(SPARE_ADDR, 32'h0000_0007);
    check_pause_readback();
    send_text("AN");
    settle();
  endtask

  // Random messages over a series of pause settings.
  task automatic test_random_messages();
    logic [PAUSE_W-1:0] p;
    logic [CHAR_W-1:0]  ch;
    int                 msg_len;
    int                 sent;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: p = '0;
        1: p = PAUSE_MAX;
        2: p = '1;
        default: p = PAUSE_W'($urandom_range(0, 63));
      endcase
      apb_write(PAUSE_ADDR, {(APB_DW-PAUSE_W)'($urandom), p});
      check_pause_readback();
      sent = 0;
      while (sent < 55) begin
        msg_len = $urandom_range(1, 8);
        for (int i = 0; i < msg_len; i++) begin
          case ($urandom_range(0, 19))
            0, 1: ch = CHAR_W'($urandom_range(0, 255));
            2:    ch = " ";
            default: ch = CHAR_A + CHAR_W'($urandom_range(0, 25));
          endcase
          send_char(ch, i == msg_len - 1);
        end
        sent += msg_len;
      end
      settle();
    end
  endtask

  // Back-to-back characters with no stalls on either side.
  task automatic test_full_rate();
    logic [CHAR_W-1:0] ch;
    quiet = 1'b1;
    apb_write(PAUSE_ADDR, 32'd2);
    for (int i = 0; i < 60; i++) begin
      ch = ($urandom_range(0, 9) == 0) ? " " : CHAR_A + CHAR_W'($urandom_range(0, 25));
      send_char(ch, $urandom_range(0, 5) == 0);
    end
    settle();
  endtask

  // Output ready: random stall bursts, stall-free stretches, none when quiet.
  int stall_left;
  int calm_left;
  always @(posedge clk) begin
    if (quiet) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm_left > 0) begin
      out_if.ready <= 1'b1;
      calm_left <= calm_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          out_if.ready <= 1'b0;
          stall_left <= $urandom_range(0, 12);
        end
        3: begin
          out_if.ready <= 1'b1;
          calm_left <= $urandom_range(20, 80);
        end
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // Compare each taken keying unit with the oldest expectation.
  always @(posedge clk) begin
    key_unit_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      units_seen++;
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected unit led=%b last=%b", $time, out_if.led_on, out_if.last_bit);
        mismatches++;
      end else begin
        want = pending_units.pop_front();
        if (out_if.led_on !== want.led_on) begin
          $display("%0t: led_on expected %b, got %b", $time, want.led_on, out_if.led_on);
          mismatches++;
        end
        if (out_if.last_bit !== want.last_bit) begin
          $display("%0t: last_bit expected %b, got %b", $time, want.last_bit, out_if.last_bit);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d units outstanding", $time, pending_units.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.character <= '0;
    in_if.end_of_message <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pause_setting = PAUSE_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_pause();
    test_code_extremes();
    test_unknown_codes();
    test_pause_edges();
    test_random_messages();
    test_full_rate();

    repeat (20) @(posedge clk);
    $display("Sent %0d characters and checked %0d keying units.", chars_sent, units_seen);
    $display("Pause register written %0d times, from zero through saturation.", reg_writes);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
